[rtl/bmpt_pkg.sv]
// Shared types, widths and a helper function for the blind position tracker.
`default_nettype none

package bmpt_pkg;

    localparam int unsigned TIME_W     = 16;
    localparam int unsigned STAMP_W    = 32;
    localparam int unsigned PCT_W      = 7;
    localparam int unsigned DIVIDEND_W = TIME_W + PCT_W;
    localparam int unsigned QIDX_W     = $clog2(PCT_W);

    localparam logic [TIME_W-1:0]     FULL_TRAVEL_RESET = 16'd20000;
    localparam logic [DIVIDEND_W-1:0] PCT_SCALE         = 23'd100;
    localparam logic [PCT_W-1:0]      PCT_STEP          = 7'd5;

    typedef enum logic [1:0] {
        MOT_STOP     = 2'd0,
        MOT_UP       = 2'd1,
        MOT_DOWN     = 2'd2,
        MOT_CONFLICT = 2'd3
    } motion_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_SCALE,
        ST_DIVIDE,
        ST_EMIT
    } seq_state_t;

    // Round a percentage to the nearest step of five, remainder above two rounds up.
    // p/5 is taken as (p*205)>>10, exact for p below 1024.
    function automatic logic [PCT_W-1:0] round_to_step(input logic [PCT_W-1:0] p);
        logic [16:0]      prod;
        logic [PCT_W-1:0] q;
        logic [PCT_W-1:0] base;
        logic [PCT_W-1:0] rem;
        prod = {10'd0, p} * 17'd205;
        q    = prod[16:10];
        base = PCT_W'(q * PCT_STEP);
        rem  = p - base;
        if (rem > 7'd2) begin
            return PCT_W'(base + PCT_STEP);
        end
        return base;
    endfunction

endpackage

`default_nettype wire

[rtl/bmpt_div.sv]
// Iterative restoring divider, one quotient bit per cycle, for the percentage.
`default_nettype none

module bmpt_div (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               start,
    input  wire logic [bmpt_pkg::DIVIDEND_W-1:0]    dividend,
    input  wire logic [bmpt_pkg::TIME_W-1:0]        divisor,
    output logic                                    done,
    output logic [bmpt_pkg::PCT_W-1:0]              quotient
);

    localparam int unsigned DW = bmpt_pkg::DIVIDEND_W;
    localparam int unsigned QW = bmpt_pkg::PCT_W;
    localparam int unsigned IW = bmpt_pkg::QIDX_W;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [IW-1:0]           idx_reg, idx_next;
    logic [DW-1:0]           rem_reg, rem_next;
    logic [QW-1:0]           quot_reg, quot_next;
    logic [bmpt_pkg::TIME_W-1:0] dvs_reg, dvs_next;
    logic [DW-1:0]           trial;

    // Quotient never exceeds the top bit position as dividend <= 100 * divisor.
    assign trial = {{(DW - bmpt_pkg::TIME_W){1'b0}}, dvs_reg} << idx_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        idx_next  = idx_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            idx_next  = IW'(QW - 1);
            rem_next  = dividend;
            quot_next = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (rem_reg >= trial) begin
                rem_next  = rem_reg - trial;
                quot_next = quot_reg | (QW'(1) << idx_reg);
            end
            if (idx_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                idx_next = idx_reg - IW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        idx_reg  <= idx_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

[rtl/blind_motion_position_tracker_core.sv]
// Top level of the time-based blind position tracker: sequencer, state and result register.
//
// Input stream (s_axis_*): one transaction per button sample, carrying both
// button levels and a free-running millisecond stamp. Output stream (m_axis_*):
// one transaction per input, giving motion state, rounded percentage and the
// travel time in milliseconds. cfg_wr_en/cfg_wr_data load full travel time.
//
// Steps: accept then emit for a sample that moves no interval; accept, clamp,
// emit with zero full travel; when an interval is applied: accept, clamp,
// scale, 7 divider steps, completion, emit. The divider yields one quotient
// bit per cycle. One sample is in flight at a time; s_axis_tready is high
// only while the sequencer is idle.
// The result sits in an output register, so the next sample is taken while a
// result still waits; if the receiver stalls, the sequencer holds in its emit
// step until the register frees, then s_axis_tready returns.
// Reset (aresetn low, synchronous) stops motion, clears position, stamp and
// timing, empties the output register and sets full travel to 20000 ms.
`default_nettype none

module blind_motion_position_tracker_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // tdata: [0] up_pressed, [1] down_pressed, [33:2] now_ms, [39:34] zero
    input  wire logic [39:0] s_axis_tdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: [1:0] motion, [8:2] position_percent, [24:9] position_time, [31:25] zero
    output logic [31:0]      m_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data
);

    localparam int unsigned TW = bmpt_pkg::TIME_W;
    localparam int unsigned SW = bmpt_pkg::STAMP_W;
    localparam int unsigned PW = bmpt_pkg::PCT_W;
    localparam int unsigned DW = bmpt_pkg::DIVIDEND_W;

    bmpt_pkg::seq_state_t state_reg, state_next;
    bmpt_pkg::motion_t    motion_reg, motion_next;
    bmpt_pkg::motion_t    prev_reg, prev_next;
    bmpt_pkg::motion_t    motion_new;

    logic          timing_reg, timing_next;
    logic [TW-1:0] travel_reg, travel_next;
    logic [SW-1:0] stamp_reg, stamp_next;
    logic [PW-1:0] pct_reg, pct_next;
    logic [TW-1:0] full_reg;
    logic [SW-1:0] elapsed_reg, elapsed_next;
    logic          upward_reg, upward_next;
    logic [31:0]   mdata_reg, mdata_next;
    logic          mvalid_reg, mvalid_next;

    logic          up_in, dn_in;
    logic [SW-1:0] now_in;
    logic          accept;
    logic          out_free;
    logic          div_start, div_done;
    logic [PW-1:0] div_quot;
    logic [DW-1:0] dividend;
    logic [SW:0]   t_cand;
    logic [TW-1:0] t_clamped;
    logic          stop_new;

    assign up_in  = s_axis_tdata[0];
    assign dn_in  = s_axis_tdata[1];
    assign now_in = s_axis_tdata[33:2];
    assign accept = s_axis_tvalid && s_axis_tready;
    assign out_free = !mvalid_reg || m_axis_tready;

    // Button decode; down wins from stop when both are pressed.
    always_comb begin
        unique case (motion_reg)
            bmpt_pkg::MOT_STOP: begin
                if (dn_in)      motion_new = bmpt_pkg::MOT_DOWN;
                else if (up_in) motion_new = bmpt_pkg::MOT_UP;
                else            motion_new = bmpt_pkg::MOT_STOP;
            end
            bmpt_pkg::MOT_UP: begin
                if (!up_in && !dn_in)     motion_new = bmpt_pkg::MOT_STOP;
                else if (!up_in && dn_in) motion_new = bmpt_pkg::MOT_CONFLICT;
                else                      motion_new = bmpt_pkg::MOT_UP;
            end
            bmpt_pkg::MOT_DOWN: begin
                if (!up_in && !dn_in)     motion_new = bmpt_pkg::MOT_STOP;
                else if (up_in && !dn_in) motion_new = bmpt_pkg::MOT_CONFLICT;
                else                      motion_new = bmpt_pkg::MOT_DOWN;
            end
            default: begin
                if (!up_in && !dn_in) motion_new = bmpt_pkg::MOT_STOP;
                else                  motion_new = bmpt_pkg::MOT_CONFLICT;
            end
        endcase
    end

    assign stop_new = (motion_new == bmpt_pkg::MOT_STOP) ||
                      (motion_new == bmpt_pkg::MOT_CONFLICT);

    // Interval update: 33-bit sum or floored difference, then clamp to full travel.
    always_comb begin
        if (upward_reg) begin
            t_cand = {{(SW - TW + 1){1'b0}}, travel_reg} + {1'b0, elapsed_reg};
        end else if (elapsed_reg >= {{(SW - TW){1'b0}}, travel_reg}) begin
            t_cand = '0;
        end else begin
            t_cand = {1'b0, {{(SW - TW){1'b0}}, travel_reg} - elapsed_reg};
        end
        if (t_cand > {{(SW - TW + 1){1'b0}}, full_reg}) begin
            t_clamped = full_reg;
        end else begin
            t_clamped = t_cand[TW-1:0];
        end
    end

    assign dividend = {{(DW - TW){1'b0}}, travel_reg} * bmpt_pkg::PCT_SCALE;

    // Sequencer: next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bmpt_pkg::ST_IDLE: begin
                if (accept) begin
                    if (stop_new) begin
                        state_next = ((prev_reg == bmpt_pkg::MOT_UP) ||
                                      (prev_reg == bmpt_pkg::MOT_DOWN))
                                     ? bmpt_pkg::ST_CLAMP : bmpt_pkg::ST_EMIT;
                    end else begin
                        state_next = timing_reg ? bmpt_pkg::ST_CLAMP : bmpt_pkg::ST_EMIT;
                    end
                end
            end
            bmpt_pkg::ST_CLAMP: begin
                state_next = (full_reg == '0) ? bmpt_pkg::ST_EMIT : bmpt_pkg::ST_SCALE;
            end
            bmpt_pkg::ST_SCALE: begin
                state_next = bmpt_pkg::ST_DIVIDE;
            end
            bmpt_pkg::ST_DIVIDE: begin
                if (div_done) state_next = bmpt_pkg::ST_EMIT;
            end
            bmpt_pkg::ST_EMIT: begin
                if (out_free) state_next = bmpt_pkg::ST_IDLE;
            end
            default: begin
                state_next = bmpt_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer: outputs.
    always_comb begin
        s_axis_tready = (state_reg == bmpt_pkg::ST_IDLE);
        div_start     = (state_reg == bmpt_pkg::ST_SCALE);
    end

    // Tracker state and result register.
    always_comb begin
        motion_next  = motion_reg;
        prev_next    = prev_reg;
        timing_next  = timing_reg;
        travel_next  = travel_reg;
        stamp_next   = stamp_reg;
        pct_next     = pct_reg;
        elapsed_next = elapsed_reg;
        upward_next  = upward_reg;
        mdata_next   = mdata_reg;
        mvalid_next  = mvalid_reg && !m_axis_tready;

        if (accept) begin
            motion_next  = motion_new;
            prev_next    = motion_new;
            elapsed_next = now_in - stamp_reg;
            if (stop_new) begin
                timing_next = 1'b0;
                upward_next = (prev_reg == bmpt_pkg::MOT_UP);
            end else begin
                timing_next = 1'b1;
                upward_next = (motion_new == bmpt_pkg::MOT_UP);
                stamp_next  = now_in;
            end
        end

        if (state_reg == bmpt_pkg::ST_CLAMP) begin
            travel_next = t_clamped;
            if (full_reg == '0) pct_next = '0;
        end

        if ((state_reg == bmpt_pkg::ST_DIVIDE) && div_done) begin
            pct_next = bmpt_pkg::round_to_step(div_quot);
        end

        if ((state_reg == bmpt_pkg::ST_EMIT) && out_free) begin
            mdata_next  = {7'd0, travel_reg, pct_reg, motion_reg};
            mvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= bmpt_pkg::ST_IDLE;
            motion_reg <= bmpt_pkg::MOT_STOP;
            prev_reg   <= bmpt_pkg::MOT_STOP;
            timing_reg <= 1'b0;
            travel_reg <= '0;
            stamp_reg  <= '0;
            pct_reg    <= '0;
            full_reg   <= bmpt_pkg::FULL_TRAVEL_RESET;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            motion_reg <= motion_next;
            prev_reg   <= prev_next;
            timing_reg <= timing_next;
            travel_reg <= travel_next;
            stamp_reg  <= stamp_next;
            pct_reg    <= pct_next;
            mvalid_reg <= mvalid_next;
            if (cfg_wr_en) full_reg <= cfg_wr_data;
        end
        elapsed_reg <= elapsed_next;
        upward_reg  <= upward_next;
        mdata_reg   <= mdata_next;
    end

    bmpt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (full_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign m_axis_tdata  = mdata_reg;
    assign m_axis_tvalid = mvalid_reg;

endmodule

`default_nettype wire

[tb/sv/tb_blind_motion_position_tracker_core.sv]
// Self-checking testbench for the blind position tracker core: directed table, then random gestures.
module tb_blind_motion_position_tracker_core;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned IDLE_PCT     = 19;
    localparam int unsigned PCT_FULL     = 100;
    localparam int unsigned PCT_ROUND    = 5;
    localparam int unsigned N_DIRECTED   = 24;
    localparam int unsigned N_PHASES     = 8;
    localparam int unsigned PHASE_ITEMS  = 100;

    // One result transaction as the block reports it.
    typedef struct packed {
        bmpt_pkg::motion_t           motion;
        logic [bmpt_pkg::PCT_W-1:0]  pct;
        logic [bmpt_pkg::TIME_W-1:0] ptime;
    } position_report_t;

    // Directed row; the expected report is only used when 'typed' is set.
    typedef struct packed {
        logic              up;
        logic              dn;
        logic [31:0]       now;
        logic              typed;
        position_report_t  rpt;
    } sample_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [39:0] s_axis_tdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;

    // Predicted tracker state, kept in step with every accepted sample.
    bmpt_pkg::motion_t            trk_motion = bmpt_pkg::MOT_STOP;
    bmpt_pkg::motion_t            trk_prev   = bmpt_pkg::MOT_STOP;
    logic                         trk_timing = 1'b0;
    logic [bmpt_pkg::TIME_W-1:0]  trk_time   = '0;
    logic [bmpt_pkg::STAMP_W-1:0] trk_stamp  = '0;
    logic [bmpt_pkg::PCT_W-1:0]   trk_pct    = '0;
    logic [bmpt_pkg::TIME_W-1:0]  trk_full   = bmpt_pkg::FULL_TRAVEL_RESET;

    position_report_t pending_reports [$];
    int unsigned      errors = 0;
    int unsigned      cycles = 0;
    bit               calm   = 1'b0;   // no idling on either side while set

    // Directed walk through the motion transitions and the edge cases of the interval maths.
    sample_row_t directed_rows [0:N_DIRECTED-1] = '{
        '{1'b0, 1'b0, 32'd0,          1'b1, '{bmpt_pkg::MOT_STOP, 7'd0,   16'd0}},
        '{1'b1, 1'b0, 32'd100,        1'b1, '{bmpt_pkg::MOT_UP,   7'd0,   16'd0}},
        '{1'b1, 1'b0, 32'd4100,       1'b0, '0},
        '{1'b1, 1'b0, 32'd4201,       1'b0, '0},
        '{1'b0, 1'b0, 32'd5000,       1'b0, '0},   // stop applies last interval
        '{1'b1, 1'b1, 32'd6000,       1'b0, '0},   // both from stop: down wins
        '{1'b0, 1'b1, 32'd7000,       1'b0, '0},
        '{1'b1, 1'b0, 32'd7500,       1'b0, '0},   // down then up alone: conflict
        '{1'b1, 1'b1, 32'd8000,       1'b0, '0},
        '{1'b0, 1'b1, 32'd8050,       1'b0, '0},
        '{1'b0, 1'b0, 32'd8100,       1'b0, '0},
        '{1'b1, 1'b0, 32'd9000,       1'b0, '0},
        '{1'b1, 1'b0, 32'hFFFF_FFFF,  1'b1, '{bmpt_pkg::MOT_UP,   7'd100, 16'd20000}},
        '{1'b1, 1'b1, 32'hFFFF_FFF0,  1'b0, '0},   // both while up keeps up
        '{1'b0, 1'b1, 32'h0000_0010,  1'b0, '0},   // stamp wraps past zero
        '{1'b0, 1'b0, 32'd20,         1'b0, '0},
        '{1'b0, 1'b1, 32'd10,         1'b0, '0},
        '{1'b0, 1'b1, 32'd5,          1'b1, '{bmpt_pkg::MOT_DOWN, 7'd0,   16'd0}},
        '{1'b1, 1'b1, 32'd7,          1'b0, '0},
        '{1'b1, 1'b0, 32'd9,          1'b0, '0},
        '{1'b0, 1'b0, 32'd11,         1'b0, '0},
        '{1'b1, 1'b0, 32'hFFFF_FF00,  1'b0, '0},
        '{1'b1, 1'b0, 32'h0000_0100,  1'b0, '0},
        '{1'b0, 1'b0, 32'h0000_0200,  1'b0, '0}
    };

    // Full-travel settings for the random phases; zero clamps everything to zero.
    logic [15:0] travel_settings [0:N_PHASES-1];

    blind_motion_position_tracker_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    function automatic bmpt_pkg::motion_t motion_after(bmpt_pkg::motion_t cur, logic up,
                                                       logic dn);
        case (cur)
            bmpt_pkg::MOT_STOP: begin
                return dn ? bmpt_pkg::MOT_DOWN : (up ? bmpt_pkg::MOT_UP : bmpt_pkg::MOT_STOP);
            end
            bmpt_pkg::MOT_UP: begin
                return (!up && !dn) ? bmpt_pkg::MOT_STOP :
                       ((!up && dn) ? bmpt_pkg::MOT_CONFLICT : bmpt_pkg::MOT_UP);
            end
            bmpt_pkg::MOT_DOWN: begin
                return (!up && !dn) ? bmpt_pkg::MOT_STOP :
                       ((up && !dn) ? bmpt_pkg::MOT_CONFLICT : bmpt_pkg::MOT_DOWN);
            end
            default: begin
                return (!up && !dn) ? bmpt_pkg::MOT_STOP : bmpt_pkg::MOT_CONFLICT;
            end
        endcase
    endfunction

    // Apply one interval to the travel time, clamp, and rescale to a rounded percentage.
    function automatic void travel_update(logic upward, logic [bmpt_pkg::STAMP_W-1:0] now);
        logic [bmpt_pkg::STAMP_W-1:0] elapsed;
        logic [33:0]                  sum;
        int unsigned                  pct;
        int unsigned                  rem;
        elapsed = now - trk_stamp;   // modulo 2^32
        if (upward) begin
            sum = {18'd0, trk_time} + {2'd0, elapsed};
        end else if ({16'd0, trk_time} <= elapsed) begin
            sum = '0;
        end else begin
            sum = {18'd0, trk_time} - {2'd0, elapsed};
        end
        if (sum > {18'd0, trk_full}) begin
            sum = {18'd0, trk_full};
        end
        trk_time = sum[bmpt_pkg::TIME_W-1:0];
        if (trk_full == '0) begin
            pct = 0;
        end else begin
            pct = (int'(trk_time) * PCT_FULL) / int'(trk_full);
        end
        rem = pct % PCT_ROUND;
        if (rem > 2) begin
            pct = pct + (PCT_ROUND - rem);
        end else begin
            pct = pct - rem;
        end
        trk_pct = bmpt_pkg::PCT_W'(pct);
    endfunction

    // Advance the predicted state by one sample and return the report it yields.
    function automatic position_report_t track_sample(logic up, logic dn, logic [31:0] now);
        bmpt_pkg::motion_t nxt;
        nxt = motion_after(trk_motion, up, dn);
        trk_motion = nxt;
        if (nxt == bmpt_pkg::MOT_STOP || nxt == bmpt_pkg::MOT_CONFLICT) begin
            trk_timing = 1'b0;
            if (trk_prev == bmpt_pkg::MOT_DOWN) begin
                travel_update(1'b0, now);
            end else if (trk_prev == bmpt_pkg::MOT_UP) begin
                travel_update(1'b1, now);
            end
        end else begin
            if (trk_timing) begin
                travel_update(nxt == bmpt_pkg::MOT_UP, now);
            end else begin
                trk_timing = 1'b1;   // first item of a move only starts timing
            end
            trk_stamp = now;
        end
        trk_prev = nxt;
        return '{nxt, trk_pct, trk_time};
    endfunction

    // Offer one sample and hold it until the block takes it. Called just after a rising
    // edge; tvalid stays high on return so back-to-back transactions need no re-raise.
    task automatic send_sample(input logic up, input logic dn, input logic [31:0] now,
                               output position_report_t predicted);
        if (take_break()) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge aclk); while (take_break());
        end
        s_axis_tdata  <= {6'd0, now, dn, up};
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predicted = track_sample(up, dn, now);
    endtask

    // Wait for every outstanding report, then load full travel while the block is idle.
    task automatic load_full_travel(input logic [15:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        trk_full = value;   // takes effect at the next interval update
    endtask

    // Result side: random back-pressure, and a field-by-field check of each transaction.
    always @(posedge aclk) begin
        position_report_t want;
        position_report_t got;
        m_axis_tready <= !take_break();
        got = '{bmpt_pkg::motion_t'(m_axis_tdata[1:0]), m_axis_tdata[8:2],
                m_axis_tdata[24:9]};
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time,
                         m_axis_tdata);
                errors++;
            end else begin
                want = pending_reports.pop_front();
                if (got.motion != want.motion) begin
                    $display("%0t: motion expected %0d actual %0d", $time,
                             want.motion, got.motion);
                    errors++;
                end
                if (got.pct != want.pct) begin
                    $display("%0t: position_percent expected %0d actual %0d", $time,
                             want.pct, got.pct);
                    errors++;
                end
                if (got.ptime != want.ptime) begin
                    $display("%0t: position_time expected %0d actual %0d", $time,
                             want.ptime, got.ptime);
                    errors++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        position_report_t predicted;
        logic [31:0]      stamp;
        logic [1:0]       gesture;
        logic [1:0]       buttons;
        int unsigned      hold;
        int unsigned      span;
        int unsigned      roll;

        travel_settings[0] = 16'd1;
        travel_settings[1] = 16'hFFFF;
        travel_settings[2] = 16'd0;
        travel_settings[3] = 16'($urandom_range(1, 65535));
        travel_settings[4] = 16'd100;
        travel_settings[5] = 16'd3;
        travel_settings[6] = bmpt_pkg::FULL_TRAVEL_RESET;
        travel_settings[7] = 16'($urandom_range(1, 65535));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part runs on the reset value of full travel.
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_sample(directed_rows[i].up, directed_rows[i].dn, directed_rows[i].now,
                        predicted);
            pending_reports.push_back(directed_rows[i].typed ? directed_rows[i].rpt
                                                             : predicted);
        end

        // Random part: held gestures with a release at the end, plus some noise.
        // Phases swap full travel mid-gesture, so a lowered value meets an old position.
        stamp = 32'h0000_0300;
        hold  = 0;
        gesture = 2'b00;
        for (int p = 0; p < N_PHASES; p++) begin
            load_full_travel(travel_settings[p]);
            calm = (p == 1);   // one whole phase with no idling on either side
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (hold == 0) begin
                    roll = $urandom_range(0, 9);
                    if (roll < 4) begin
                        gesture = 2'b01;   // up
                    end else if (roll < 8) begin
                        gesture = 2'b10;   // down
                    end else if (roll == 8) begin
                        gesture = 2'b11;
                    end else begin
                        gesture = 2'b00;
                    end
                    hold = $urandom_range(1, 8);
                end
                hold--;
                if ($urandom_range(0, 99) < 8) begin
                    buttons = 2'($urandom);
                end else begin
                    buttons = (hold == 0) ? 2'b00 : gesture;
                end
                // Steps mostly a fraction of the full travel; now and then any stamp.
                span = int'(trk_full) / 6 + 2;
                roll = $urandom_range(0, 99);
                if (roll < 5) begin
                    stamp = $urandom;
                end else begin
                    stamp = stamp + $urandom_range(0, span);
                end
                send_sample(buttons[0], buttons[1], stamp, predicted);
                pending_reports.push_back(predicted);
            end
        end
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;

        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
